[src/itoa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Result of one binary-to-BCD conversion, handed from the converter to the emitter.
    typedef struct packed {
        logic             done;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_bcd_res;

    // Double-dabble correction for one BCD digit before it is shifted.
    function automatic logic [DIGIT_W-1:0] dabble_adj(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        r = d;
        if (d >= 4'd5) begin
            r = d + 4'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                Transfer
// -------   ----------------------------------   ------------------------------------
// input     start, busy, i_value                 edge with start high and busy low
// result    o_valid, o_character, o_last_char    edge that ends a cycle with o_valid
//
// A number goes first through the converter, which shifts one bit per cycle into ten BCD
// digits, and then to the emitter, which takes the digits when the converter flags done.
// The emitter sends a minus sign for a negative value, drops each leading zero, stops on
// the first kept digit position before sending starts, and then sends the digits.
// Reset is synchronous and active low; it returns both units to idle.
// The receiver cannot stall: each character is shown for exactly one cycle.
// busy stays high from the accepting edge until the last character has gone and falls
// in the next cycle, so the input takes no new value while a number is still in progress.
module int_to_decimal_ascii (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [itoa_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]              o_character,
    output logic                                     o_last_char
);

    logic                          w_accept;
    logic                          w_neg;
    logic [itoa_pkg::VALUE_W-1:0]  w_mag;
    logic                          w_bcd_busy;
    logic                          w_emit_busy;
    itoa_pkg::t_bcd_res            w_res;

    assign w_accept = start && !busy;

    // Magnitude in unsigned arithmetic: the most negative value maps onto
    // 2147483648 with no special handling.
    assign w_neg = i_value[itoa_pkg::VALUE_W-1];
    assign w_mag = w_neg ? (itoa_pkg::VALUE_W'(0) - itoa_pkg::VALUE_W'(i_value))
                         : itoa_pkg::VALUE_W'(i_value);

    itoa_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_neg   (w_neg),
        .i_mag   (w_mag),
        .o_busy  (w_bcd_busy),
        .o_res   (w_res)
    );

    // The emitter picks up the BCD word in the cycle the converter flags done,
    // then prints a minus sign for a negative value, drops leading zeros and sends the digits.
    itoa_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .o_busy      (w_emit_busy),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    assign busy = w_bcd_busy || w_emit_busy;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("character transfer while not busy");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == itoa_pkg::CHAR_MINUS ||
                     (o_character >= itoa_pkg::CHAR_ZERO &&
                      o_character <= itoa_pkg::CHAR_NINE)))
        else $error("character outside sign and digit set");

endmodule

`default_nettype wire

[src/itoa_bcd.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add-3 converter: one binary bit enters the BCD register per cycle.
module itoa_bcd (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_neg,
    input  wire logic [itoa_pkg::VALUE_W-1:0]  i_mag,
    output logic                               o_busy,
    output itoa_pkg::t_bcd_res                 o_res
);

    localparam int CNT_W = $clog2(itoa_pkg::VALUE_W);

    logic                          r_run;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [itoa_pkg::VALUE_W-1:0]  r_bin;
    logic [itoa_pkg::BCD_W-1:0]    r_bcd;
    logic                          r_neg;
    logic [itoa_pkg::BCD_W-1:0]    n_bcd;
    logic [itoa_pkg::BCD_W-1:0]    w_adj;

    always_comb begin
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
            w_adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
                itoa_pkg::dabble_adj(r_bcd[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W]);
        end
        n_bcd = {w_adj[itoa_pkg::BCD_W-2:0], r_bin[itoa_pkg::VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(itoa_pkg::VALUE_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
            r_neg <= i_neg;
        end else if (r_run) begin
            r_bin <= {r_bin[itoa_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_busy     = r_run | r_done;
    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.bcd  = r_bcd;

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("conversion done while still shifting");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_run && r_cnt == '0))
        else $error("load did not start a conversion");

endmodule

`default_nettype wire

[src/itoa_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Character emitter: shifts the BCD word out one digit per cycle, most significant first.
module itoa_emit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire itoa_pkg::t_bcd_res           i_res,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]       o_character,
    output logic                              o_last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SIGN = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int LEFT_W = $clog2(itoa_pkg::NUM_DIGITS + 1);

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [LEFT_W-1:0]           r_left;
    logic [itoa_pkg::BCD_W-1:0]  r_digits;
    logic [itoa_pkg::DIGIT_W-1:0] w_top;
    logic                        w_shift;

    assign w_top = r_digits[itoa_pkg::BCD_W-1 -: itoa_pkg::DIGIT_W];

    always_comb begin
        n_state = r_state;
        w_shift = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_res.done) begin
                    n_state = i_res.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (w_top == '0 && r_left != LEFT_W'(1)) begin
                    w_shift = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_shift = 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_res.done) begin
            r_digits <= i_res.bcd;
            r_left   <= LEFT_W'(itoa_pkg::NUM_DIGITS);
        end else if (w_shift) begin
            r_digits <= {r_digits[itoa_pkg::BCD_W-itoa_pkg::DIGIT_W-1:0],
                         {itoa_pkg::DIGIT_W{1'b0}}};
            r_left   <= r_left - 1'b1;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_SIGN) || (r_state == ST_EMIT);
    assign o_character = (r_state == ST_SIGN) ? itoa_pkg::CHAR_MINUS
                       : itoa_pkg::CHAR_ZERO + {{(itoa_pkg::CHAR_W-itoa_pkg::DIGIT_W){1'b0}}, w_top};
    assign o_last_char = (r_state == ST_EMIT) && (r_left == LEFT_W'(1));

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |=> (r_state == ST_IDLE))
        else $error("emitter kept running after the last character");

    a_emit_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_top <= 4'd9))
        else $error("non-decimal digit reached the output");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the signed 32-bit integer to decimal ASCII converter.
//
// The driver presents one value at a time on start/i_value. A transfer happens
// at the rising edge where start is high and busy is low. At that edge the
// driver spells the value out in decimal and queues the expected characters.
// The monitor compares every character the block emits, together with its
// last-character flag, against the oldest queued expectation.
module tb;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 350;
    localparam int IDLE_PERCENT  = 22;
    // Values sent while the count of transfers is in this window go back to back.
    localparam int BURST_FIRST   = 120;
    localparam int BURST_LAST    = 200;
    // The tail is longer than the slowest number takes, so it is ample.
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // One character of expected output text.
    typedef struct {
        logic [itoa_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_char;

    logic                                 i_clk   = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start   = 1'b0;
    logic signed [itoa_pkg::VALUE_W-1:0]  i_value = '0;
    logic                                 busy;
    logic                                 o_valid;
    logic [itoa_pkg::CHAR_W-1:0]          o_character;
    logic                                 o_last_char;

    logic signed [itoa_pkg::VALUE_W-1:0]  pending_values[$];
    t_text_char                           expected_text[$];

    int values_sent     = 0;
    int negatives_sent  = 0;
    int chars_checked   = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Spells a value in decimal, most significant character first, and appends
    // the characters to the expected text. The magnitude is taken as an
    // unsigned 32-bit negation, which also covers the most negative value.
    task automatic queue_decimal_text(input logic signed [itoa_pkg::VALUE_W-1:0] value);
        logic [itoa_pkg::VALUE_W-1:0] magnitude;
        logic [3:0]                   digits[itoa_pkg::NUM_DIGITS];
        int                           n_digits;
        t_text_char                   c;
        magnitude = value[itoa_pkg::VALUE_W-1] ? (32'd0 - value) : value;
        n_digits  = 0;
        do begin
            digits[n_digits] = 4'(magnitude % 32'd10);
            magnitude        = magnitude / 32'd10;
            n_digits++;
        end while (magnitude != 0 && n_digits < itoa_pkg::NUM_DIGITS);
        if (value[itoa_pkg::VALUE_W-1]) begin
            c.ch   = itoa_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            c.ch   = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digits[k]);
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endtask

    // Random values, weighted so that every digit count and both signs come up
    // often, along with decade boundaries and values near the extremes.
    function automatic logic signed [itoa_pkg::VALUE_W-1:0] pick_value();
        longint lo;
        longint hi;
        longint v;
        int     len;
        v = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = longint'($signed($urandom()));
            end
            4, 5, 6: begin
                len = $urandom_range(1, itoa_pkg::NUM_DIGITS);
                lo  = (len == 1) ? 0 : 1;
                hi  = 1;
                for (int i = 0; i < len; i++) begin
                    if (i < len - 1) begin
                        lo = (len == 1) ? 0 : lo * 10;
                    end
                    hi = hi * 10;
                end
                if (len == 1) begin
                    lo = 0;
                end else begin
                    lo = lo / 10 * 10 / 10 * 10 / 10;
                    lo = 1;
                    for (int i = 1; i < len; i++) begin
                        lo = lo * 10;
                    end
                end
                hi = hi - 1;
                if (hi > 64'sd2147483647) begin
                    hi = 64'sd2147483647;
                end
                v = lo + longint'({32'd0, $urandom()}) % (hi - lo + 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            7: begin
                v = 1;
                len = $urandom_range(0, itoa_pkg::NUM_DIGITS - 1);
                for (int i = 0; i < len; i++) begin
                    v = v * 10;
                end
                v = v + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            8: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 64'sd2147483647 - $urandom_range(0, 15);
                end else begin
                    v = -64'sd2147483648 + $urandom_range(0, 15);
                end
            end
            default: begin
                v = $urandom_range(0, 40) - 20;
            end
        endcase
        return itoa_pkg::VALUE_W'(v);
    endfunction

    // Driver. At each rising edge it records a transfer if one happened, then
    // either holds the current value, presents the next pending one, or idles.
    // start gets exactly one assignment per edge so it can stay high across
    // back-to-back transfers.
    always @(posedge i_clk) begin : driver
        logic                                next_start;
        logic signed [itoa_pkg::VALUE_W-1:0] next_value;
        logic                                burst;
        next_start = start;
        next_value = i_value;
        if (i_rst_n) begin
            if (start && !busy) begin
                queue_decimal_text(i_value);
                values_sent++;
                if (i_value < 0) begin
                    negatives_sent++;
                end
                next_start = 1'b0;
            end
            if (!next_start && pending_values.size() > 0) begin
                burst = (values_sent >= BURST_FIRST) && (values_sent < BURST_LAST);
                if (burst || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                    next_start = 1'b1;
                    next_value = pending_values.pop_front();
                end
            end
        end
        start   <= next_start;
        i_value <= next_value;
    end

    // Monitor. The block cannot be stalled, so every cycle with o_valid high is
    // a transfer of one character and is checked on the spot.
    always @(posedge i_clk) begin : monitor
        t_text_char want;
        if (i_rst_n && o_valid) begin
            if (expected_text.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("ERROR: unexpected character 0x%02h last=%0b at cycle %0d",
                             o_character, o_last_char, cycle_count);
                end
                mismatches++;
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (o_character !== want.ch || o_last_char !== want.last) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("ERROR: cycle %0d expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                                 cycle_count, want.ch, want.last, o_character, o_last_char);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d characters still expected",
                     cycle_count, expected_text.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // Directed values first: zero, single digits, decade edges, both
        // extremes including the most negative value, and alternating bits.
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd9);
        pending_values.push_back(-32'sd9);
        pending_values.push_back(32'sd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'sd99);
        pending_values.push_back(32'sd100);
        pending_values.push_back(32'sd999999999);
        pending_values.push_back(32'sd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'sd1234567890);
        pending_values.push_back(-32'sd1234567890);
        pending_values.push_back(32'sd2147483647);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'h8000_0000);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_values.push_back(pick_value());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every value has been transferred and all of its text has
        // come back, then give the block time to show any stray character.
        while (pending_values.size() > 0 || start || expected_text.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d negative), checked %0d characters.",
                 values_sent, negatives_sent, chars_checked);
        $display("Mismatches: %0d, run length %0d cycles.", mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[int_to_decimal_ascii.f]
src/itoa_pkg.sv
src/itoa_bcd.sv
src/itoa_emit.sv
src/int_to_decimal_ascii.sv
bench/tb.sv
